>>> sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the bitmap frame allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

   localparam int ADDR_W     = 32;
   localparam int KB_W       = 22;
   localparam int CNT_OUT_W  = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int WORD_BITS  = 32;
   localparam int BIT_IDX_W  = 5;

   // memory end = (upper kb + KB_OFFSET) << KB_SHIFT
   localparam int KB_OFFSET  = 1024;
   localparam int KB_SHIFT   = 10;

   // request kinds
   localparam logic [1:0] REQ_INIT  = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOMEM   = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_UPPER_KB = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_END     = 2'd2;

   // register reset values
   localparam logic [KB_W-1:0]   RST_MEM_UPPER_KB = 22'd64512;
   localparam logic [ADDR_W-1:0] RST_BASE_ADDR    = 32'h0040_0000;
   localparam logic [ADDR_W-1:0] RST_FREE_END     = 32'h0440_0000;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] frame_address;
   } bfa_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ADDR_W-1:0]    alloc_address;
      logic [CNT_OUT_W-1:0] free_count;
      logic [CNT_OUT_W-1:0] used_count;
   } bfa_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;     // latch request
      logic       clear_step;  // write all-ones word, advance pointer
      logic       init_end;    // compute clamped memory end
      logic       init_count;  // compute managed frame count
      logic       init_step;   // write init pattern word, advance pointer
      logic       scan;        // first-fit scan for a clear bit
      logic       alloc_wb;    // set found bit, bump used count
      logic       free_chk;    // range check of the freed address
      logic       free_rd;     // read word holding the freed frame
      logic       free_wb;     // clear the bit if it was set
      logic       respond;     // present the result
      logic [1:0] rsp_code;
   } bfa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;      // word pointer at last word
      logic hit;       // scanned word has a clear bit
      logic scan_end;  // last word scanned
      logic free_ok;   // freed frame in range
      logic bit_set;   // freed frame currently used
   } bfa_sts_type;

endpackage

`default_nettype wire

>>> sv/bfa_datapath.sv
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap memory, word pointer, counters, config registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_datapath #(
   parameter int FRAME_COUNT = 16384,
   parameter int PAGE_SHIFT  = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bfa_pkg::bfa_req_type            req_data,
   input  wire logic                            csr_we,
   input  wire logic [bfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bfa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire bfa_pkg::bfa_cmd_type            cmd,
   output bfa_pkg::bfa_sts_type                 sts,
   output logic                                 rsp_valid,
   output bfa_pkg::bfa_rsp_type                 rsp_data
);
   import bfa_pkg::*;

   localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int FB_W       = WIDX_W + BIT_IDX_W;
   localparam int CNT_W      = $clog2(FRAME_COUNT + 1);
   localparam int CMP_W      = ((FB_W > CNT_W) ? FB_W : CNT_W) + 1;
   localparam int END_W      = ADDR_W + 1;
   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORD_COUNT - 1);

   // config registers
   logic [KB_W-1:0]   kb_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] free_end_ff;

   // request and working registers
   bfa_req_type       req_ff;
   logic [WIDX_W-1:0] wptr_ff;
   logic              scan_stop_ff;
   logic              rd_vld_ff;
   logic              rd_last_ff;
   logic [WIDX_W-1:0] rd_widx_ff;
   logic [WIDX_W-1:0] hit_widx_ff;
   logic [WORD_BITS-1:0] hit_word_ff;
   logic [BIT_IDX_W-1:0] hit_pos_ff;
   logic [ADDR_W-1:0] end_ff;
   logic [FB_W-1:0]   free_frame_ff;
   logic              free_ok_ff;
   logic [CNT_W-1:0]  managed_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [ADDR_W-1:0] alloc_addr_ff;
   logic              rsp_valid_ff;
   bfa_rsp_type       rsp_ff;

   // bitmap memory
   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] mem_rdata_ff;
   logic                 mem_we;
   logic [WIDX_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [WIDX_W-1:0]    mem_raddr;

   // combinational helpers
   logic [BIT_IDX_W-1:0] zero_pos;
   logic [WORD_BITS-1:0] init_word;
   logic [CMP_W-1:0]     cmp_managed;
   logic [CMP_W-1:0]     cmp_base;
   logic [END_W-1:0]     end_raw;
   logic [ADDR_W-1:0]    end_clamped;
   logic [ADDR_W-1:0]    span;
   logic [ADDR_W-1:0]    span_frames;
   logic [CNT_W-1:0]     managed_in;
   logic [ADDR_W-1:0]    free_off;
   logic [ADDR_W-1:0]    free_frame;
   logic                 free_ok_in;
   logic [WIDX_W-1:0]    free_widx;
   logic [BIT_IDX_W-1:0] free_bit;
   logic [FB_W-1:0]      hit_frame;
   logic [2*ADDR_W-1:0]  hit_offset;
   logic [CNT_W-1:0]     free_cnt;
   logic                 scan_issue;

   assign free_widx  = free_frame_ff[FB_W-1:BIT_IDX_W];
   assign free_bit   = free_frame_ff[BIT_IDX_W-1:0];
   assign hit_frame  = {hit_widx_ff, hit_pos_ff};
   assign hit_offset = (2*ADDR_W)'(hit_frame) << PAGE_SHIFT;
   assign scan_issue = cmd.scan && !scan_stop_ff;

   // lowest clear bit of the word just read
   always_comb begin
      zero_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!mem_rdata_ff[i]) begin
            zero_pos = BIT_IDX_W'(i);
         end
      end
   end

   // init pattern: frames below the managed count are clear
   always_comb begin
      cmp_managed = CMP_W'(managed_ff);
      cmp_base    = CMP_W'({wptr_ff, BIT_IDX_W'(0)});
      if (cmp_managed >= cmp_base + CMP_W'(WORD_BITS)) begin
         init_word = '0;
      end else if (cmp_managed <= cmp_base) begin
         init_word = '1;
      end else begin
         init_word = {WORD_BITS{1'b1}} << managed_ff[BIT_IDX_W-1:0];
      end
   end

   always_comb begin
      end_raw = END_W'({(KB_W+1)'(kb_ff) + (KB_W+1)'(KB_OFFSET), KB_SHIFT'(0)});
      if (end_raw > END_W'(free_end_ff)) begin
         end_clamped = free_end_ff;
      end else begin
         end_clamped = end_raw[ADDR_W-1:0];
      end
   end

   always_comb begin
      span        = end_ff - base_ff;
      span_frames = span >> PAGE_SHIFT;
      if (end_ff < base_ff) begin
         managed_in = '0;
      end else if (span_frames > ADDR_W'(FRAME_COUNT)) begin
         managed_in = CNT_W'(FRAME_COUNT);
      end else begin
         managed_in = CNT_W'(span_frames);
      end
   end

   always_comb begin
      free_off   = req_ff.frame_address - base_ff;
      free_frame = free_off >> PAGE_SHIFT;
      free_ok_in = (req_ff.frame_address >= base_ff) &&
                   (free_frame < ADDR_W'(managed_ff));
   end

   // memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wptr_ff;
      mem_wdata = '1;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.init_step) begin
         mem_we    = 1'b1;
         mem_wdata = init_word;
      end else if (cmd.alloc_wb) begin
         mem_we    = 1'b1;
         mem_waddr = hit_widx_ff;
         mem_wdata = hit_word_ff | (WORD_BITS'(1) << hit_pos_ff);
      end else if (cmd.free_wb && sts.bit_set) begin
         mem_we    = 1'b1;
         mem_waddr = free_widx;
         mem_wdata = mem_rdata_ff & ~(WORD_BITS'(1) << free_bit);
      end
      mem_re    = scan_issue || cmd.free_rd;
      mem_raddr = cmd.free_rd ? free_widx : wptr_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // status to controller
   always_comb begin
      sts.last     = (wptr_ff == LAST_WORD);
      sts.hit      = rd_vld_ff && (mem_rdata_ff != '1);
      sts.scan_end = rd_vld_ff && rd_last_ff;
      sts.free_ok  = free_ok_ff;
      sts.bit_set  = mem_rdata_ff[free_bit];
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kb_ff       <= RST_MEM_UPPER_KB;
         base_ff     <= RST_BASE_ADDR;
         free_end_ff <= RST_FREE_END;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEM_UPPER_KB: kb_ff       <= csr_wdata[KB_W-1:0];
            CSR_BASE_ADDR:    base_ff     <= csr_wdata[ADDR_W-1:0];
            CSR_FREE_END:     free_end_ff <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         scan_stop_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         managed_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= scan_issue;
         rsp_valid_ff <= cmd.respond;
         if (cmd.capture || cmd.init_count) begin
            wptr_ff      <= '0;
            scan_stop_ff <= 1'b0;
         end else if (cmd.clear_step || cmd.init_step || scan_issue) begin
            if (sts.last) begin
               scan_stop_ff <= 1'b1;
            end else begin
               wptr_ff <= wptr_ff + WIDX_W'(1);
            end
         end
         if (cmd.init_count) begin
            managed_ff <= managed_in;
            used_ff    <= '0;
         end else if (cmd.alloc_wb) begin
            used_ff <= used_ff + CNT_W'(1);
         end else if (cmd.free_wb && sts.bit_set && used_ff != '0) begin
            used_ff <= used_ff - CNT_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff        <= req_data;
         alloc_addr_ff <= '0;
      end else if (cmd.alloc_wb) begin
         alloc_addr_ff <= base_ff + hit_offset[ADDR_W-1:0];
      end
      if (scan_issue) begin
         rd_widx_ff <= wptr_ff;
         rd_last_ff <= sts.last;
      end
      if (cmd.scan && sts.hit) begin
         hit_widx_ff <= rd_widx_ff;
         hit_word_ff <= mem_rdata_ff;
         hit_pos_ff  <= zero_pos;
      end
      if (cmd.init_end) begin
         end_ff <= end_clamped;
      end
      if (cmd.free_chk) begin
         free_ok_ff    <= free_ok_in;
         free_frame_ff <= FB_W'(free_frame);
      end
      if (cmd.respond) begin
         rsp_ff.status        <= cmd.rsp_code;
         rsp_ff.alloc_address <= alloc_addr_ff;
         rsp_ff.free_count    <= CNT_OUT_W'(free_cnt);
         rsp_ff.used_count    <= CNT_OUT_W'(used_ff);
      end
   end

   assign free_cnt  = (used_ff > managed_ff) ? '0 : managed_ff - used_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/bfa_controller.sv
// ----------------------------------------------------------------------------
// bfa_controller
// Sequencer for clearing pass, init, first-fit alloc and free requests.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_type,
   input  wire bfa_pkg::bfa_sts_type sts,
   output bfa_pkg::bfa_cmd_type      cmd,
   output logic                      busy
);
   import bfa_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_INIT_END  = 4'd2;
   localparam logic [3:0] S_INIT_CNT  = 4'd3;
   localparam logic [3:0] S_INIT_FILL = 4'd4;
   localparam logic [3:0] S_SCAN      = 4'd5;
   localparam logic [3:0] S_ALLOC_WB  = 4'd6;
   localparam logic [3:0] S_FREE_CHK  = 4'd7;
   localparam logic [3:0] S_FREE_RD   = 4'd8;
   localparam logic [3:0] S_FREE_WB   = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [1:0] code_ff;
   logic [1:0] code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_INIT:  state_in = S_INIT_END;
                  REQ_ALLOC: state_in = S_SCAN;
                  REQ_FREE:  state_in = S_FREE_CHK;
                  default: begin
                     code_in  = ST_IGNORED;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INIT_END: begin
            cmd.init_end = 1'b1;
            state_in     = S_INIT_CNT;
         end
         S_INIT_CNT: begin
            cmd.init_count = 1'b1;
            state_in       = S_INIT_FILL;
         end
         S_INIT_FILL: begin
            cmd.init_step = 1'b1;
            if (sts.last) begin
               code_in  = ST_DONE;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               state_in = S_ALLOC_WB;
            end else if (sts.scan_end) begin
               code_in  = ST_NOMEM;
               state_in = S_DONE;
            end
         end
         S_ALLOC_WB: begin
            cmd.alloc_wb = 1'b1;
            code_in      = ST_DONE;
            state_in     = S_DONE;
         end
         S_FREE_CHK: begin
            cmd.free_chk = 1'b1;
            state_in     = S_FREE_RD;
         end
         S_FREE_RD: begin
            if (sts.free_ok) begin
               cmd.free_rd = 1'b1;
               state_in    = S_FREE_WB;
            end else begin
               code_in  = ST_IGNORED;
               state_in = S_DONE;
            end
         end
         S_FREE_WB: begin
            cmd.free_wb = 1'b1;
            code_in     = sts.bit_set ? ST_DONE : ST_IGNORED;
            state_in    = S_DONE;
         end
         S_DONE: begin
            cmd.respond  = 1'b1;
            cmd.rsp_code = code_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> sv/bitmap_frame_allocator_unit.sv
// Alloc scans with one bitmap word read per cycle on the single read port; a free
// out of range skips the read. One request at a time; busy drops with the result
// strobe. After reset a clearing pass writes all WORD_COUNT bitmap words (512 at the
// default size) with busy high; csr writes are taken throughout. The receiver cannot
// stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit page frame allocator over a one-bit-per-frame used bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator_unit #(
   parameter int FRAME_COUNT = 16384,
   parameter int PAGE_SHIFT  = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire bfa_pkg::bfa_req_type            req_data,
   output logic                                 rsp_valid,
   output bfa_pkg::bfa_rsp_type                 rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [bfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bfa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfa_pkg::*;

   bfa_cmd_type cmd;
   bfa_sts_type sts;

   bfa_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   bfa_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> sv/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level properties of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire bfa_pkg::bfa_rsp_type            rsp_data
);
   import bfa_pkg::*;

   // an accepted request raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // the result strobe arrives as the block goes idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // one result per request, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // only a completed allocation carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE) |-> (rsp_data.alloc_address == '0))
      else $error("address returned with failing status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_DONE || rsp_data.status == ST_NOMEM ||
                     rsp_data.status == ST_IGNORED))
      else $error("undefined result status");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (.*);

`default_nettype wire
